// ===== hdl/dcs_pkg.sv =====
// Shared types and constants for the DAC code scaler / serializer.
// No dependencies; every other file imports this package.
package dcs_pkg;

  localparam int CODE_BITS    = 16;
  localparam int COMMAND_BITS = 8;
  localparam int FRAME_BITS   = COMMAND_BITS + CODE_BITS;
  localparam int POS_W        = $clog2(FRAME_BITS);

  localparam int VOLT_W = 24;              // signed Q7.16
  localparam int GAIN_W = 24;              // unsigned Q8.16
  localparam int DIFF_W = VOLT_W + 1;      // signed Q8.16
  localparam int PROD_W = DIFF_W + GAIN_W; // signed Q.32
  localparam int MAG_W  = PROD_W - 1;

  // magnitudes at or above 2^SAFE_W always saturate
  localparam int SAFE_W = 39;
  // (mag * FULL) >> SCALE_SHIFT, then /5, gives mag * 2 * FULL / (5 * 2^32)
  localparam int SCALE_SHIFT = 31;
  localparam int X_W  = SAFE_W + CODE_BITS - SCALE_SHIFT;
  localparam int XM_W = CODE_BITS + 3;     // holds x below 5 * 2^CODE_BITS

  localparam logic [X_W-1:0] X_CLIP_HI = X_W'(5) << CODE_BITS;
  localparam logic [X_W-1:0] X_CLIP_LO = X_W'(5);

  // divide by 5 through a reciprocal, exact for x < 2^(RECIP_SHIFT-2)
  localparam int RECIP_SHIFT = CODE_BITS + 10;
  localparam int RECIP_W     = RECIP_SHIFT - 2;
  localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + 4) / 5;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int QP_W = XM_W + RECIP_W;

  localparam logic [CODE_BITS-1:0] CODE_FULL = '1;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTAGE_OFFSET = 2'd0,
    REG_GAIN_FACTOR    = 2'd1
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef struct packed {
    logic                 clipped;
    logic [CODE_BITS-1:0] code;
  } frame_t;

endpackage

// ===== hdl/dcs_if.sv =====
// Channel interfaces: input item, result item and configuration write.
// Depends on dcs_pkg.
interface dcs_in_if import dcs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VOLT_W-1:0] set_voltage;
  modport source (output valid, output set_voltage, input ready);
  modport sink   (input valid, input set_voltage, output ready);
endinterface

interface dcs_out_if import dcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 serial_bit;
  logic [POS_W-1:0]     bit_position;
  logic [CODE_BITS-1:0] dac_code;
  logic                 clipped;
  logic                 last_bit;
  modport source (output valid, output serial_bit, output bit_position, output dac_code,
                  output clipped, output last_bit, input ready);
  modport sink   (input valid, input serial_bit, input bit_position, input dac_code,
                  input clipped, input last_bit, output ready);
endinterface

interface dcs_cfg_if import dcs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/dcs_front.sv =====
// Front pipeline: offset subtract, gain multiply, scale and saturate.
// Depends on dcs_pkg; pushes one frame_t per item into the queue.
module dcs_front import dcs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [VOLT_W-1:0] in_set_voltage,
  output logic                     in_ready,
  input  logic signed [VOLT_W-1:0] offset,
  input  logic [GAIN_W-1:0]        gain,
  output logic                     push,
  output frame_t                   push_data,
  input  logic                     q_full
);

  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     neg3_r, big3_r;
  logic [X_W-1:0]           x3_r;
  logic                     neg4_r, clip4_r;
  logic [QP_W-1:0]          qp4_r;

  logic                       adv;
  logic signed [PROD_W-1:0]   prod_full;
  logic [MAG_W-1:0]           mag;
  logic [SAFE_W+CODE_BITS-1:0] scaled;
  logic                       clip_nxt;

  // whole pipeline moves unless its last stage is blocked by a full queue
  assign adv      = !(v4_r && q_full);
  assign in_ready = adv;
  assign push     = v4_r && adv;

  // 25 x 25 signed multiply; the exact product fits in PROD_W bits
  assign prod_full = PROD_W'(diff_r) * PROD_W'($signed({1'b0, gain}));

  // |product| * FULL as a shift and subtract
  assign mag    = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
  assign scaled = {mag[SAFE_W-1:0], {CODE_BITS{1'b0}}}
                - {{CODE_BITS{1'b0}}, mag[SAFE_W-1:0]};

  // negative: any whole step below zero clips; positive: above FULL clips
  assign clip_nxt = big3_r || (neg3_r ? (x3_r >= X_CLIP_LO) : (x3_r >= X_CLIP_HI));

  always_comb begin
    push_data.clipped = clip4_r;
    if (neg4_r) begin
      push_data.code = '0;
    end else if (clip4_r) begin
      push_data.code = CODE_FULL;
    end else begin
      push_data.code = qp4_r[RECIP_SHIFT +: CODE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r  <= DIFF_W'(in_set_voltage) - DIFF_W'(offset);
      prod_r  <= prod_full;
      neg3_r  <= prod_r[PROD_W-1];
      big3_r  <= |mag[MAG_W-1:SAFE_W];
      x3_r    <= scaled[SAFE_W+CODE_BITS-1:SCALE_SHIFT];
      neg4_r  <= neg3_r;
      clip4_r <= clip_nxt;
      qp4_r   <= QP_W'(x3_r[XM_W-1:0]) * QP_W'(RECIP);
    end
  end

endmodule

// ===== hdl/dcs_queue.sv =====
// Small FIFO of computed frames between front pipeline and serializer.
// Depends on dcs_pkg.
module dcs_queue import dcs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output frame_t pop_data
);

  frame_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wp_r, rp_r;
  logic [FIFO_AW:0]       cnt_r;

  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hdl/dcs_back.sv =====
// Serializer: sends command bits then the code MSB first, one bit per transaction.
// Depends on dcs_pkg; takes frames from dcs_queue.
module dcs_back import dcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  frame_t               q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_serial_bit,
  output logic [POS_W-1:0]     out_bit_position,
  output logic [CODE_BITS-1:0] out_dac_code,
  output logic                 out_clipped,
  output logic                 out_last_bit
);

  logic                 busy_r;
  logic [POS_W-1:0]     pos_r;
  frame_t               frame_r;
  logic [CODE_BITS-1:0] shift_r;
  logic                 take, last;

  assign last = (pos_r == POS_W'(FRAME_BITS-1));
  assign take = busy_r && out_ready;
  assign pop  = q_not_empty && (!busy_r || (take && last));

  assign out_valid        = busy_r;
  assign out_bit_position = pos_r;
  assign out_dac_code     = frame_r.code;
  assign out_clipped      = frame_r.clipped;
  assign out_last_bit     = last;
  assign out_serial_bit   = (pos_r >= POS_W'(COMMAND_BITS)) && shift_r[CODE_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      pos_r  <= '0;
    end else if (take) begin
      busy_r <= !last;
      pos_r  <= last ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      frame_r <= q_data;
      shift_r <= q_data.code;
    end else if (take && (pos_r >= POS_W'(COMMAND_BITS))) begin
      shift_r <= {shift_r[CODE_BITS-2:0], 1'b0};
    end
  end

endmodule

// ===== hdl/dac_code_scale_and_serialize.sv =====
// DAC code scaler and serial frame generator, top level.
// A frame's first bit goes out after the front stages, queue and frame register.
// The serializer sends one bit per cycle while out_ready is high, a frame at a time.
// The 4-stage front pipeline and a 2-entry queue take new items while a frame goes out.
// Reset (rst_n low, synchronous) empties pipeline, queue and serializer,
// offset returns to 0 and gain to 1.0.
module dac_code_scale_and_serialize import dcs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dcs_in_if.sink    in_ch,
  dcs_out_if.source out_ch,
  dcs_cfg_if.sink   cfg_ch
);

  // configuration registers, always writable
  logic signed [VOLT_W-1:0] offset_r;
  logic [GAIN_W-1:0]        gain_r;

  logic   push, q_full, pop, q_not_empty;
  frame_t push_data, q_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      gain_r   <= GAIN_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_VOLTAGE_OFFSET: offset_r <= VOLT_W'(cfg_ch.data);
        REG_GAIN_FACTOR:    gain_r   <= GAIN_W'(cfg_ch.data);
        default: ;          // unknown index: ignored
      endcase
    end
  end

  // front: subtract, multiply, scale and saturate
  dcs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_set_voltage (in_ch.set_voltage),
    .in_ready       (in_ch.ready),
    .offset         (offset_r),
    .gain           (gain_r),
    .push           (push),
    .push_data      (push_data),
    .q_full         (q_full)
  );

  // decouples the pipeline from the slow serializer
  dcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  // back: one result transaction per frame bit
  dcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_data           (q_data),
    .pop              (pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_serial_bit   (out_ch.serial_bit),
    .out_bit_position (out_ch.bit_position),
    .out_dac_code     (out_ch.dac_code),
    .out_clipped      (out_ch.clipped),
    .out_last_bit     (out_ch.last_bit)
  );

endmodule

// ===== hdl/dcs_checker.sv =====
// Port-level checks on the result channel of the top level, plus its bind.
// Depends on dcs_pkg and dac_code_scale_and_serialize.
module dcs_checker import dcs_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 serial_bit,
  input logic [POS_W-1:0]     bit_position,
  input logic [CODE_BITS-1:0] dac_code,
  input logic                 clipped,
  input logic                 last_bit
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bit_position) && $stable(dac_code))
    else $error("result changed while stalled");

  // frame bits come in order with no gap in valid
  a_next_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_bit |=>
      out_valid && (bit_position == $past(bit_position) + 1'b1))
    else $error("frame bit skipped or frame cut short");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (last_bit == (bit_position == POS_W'(FRAME_BITS-1))))
    else $error("last bit mark misplaced");

  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (bit_position < POS_W'(COMMAND_BITS)) |-> !serial_bit)
    else $error("command bit not zero");

  a_clip_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && clipped |-> (dac_code == '0) || (dac_code == CODE_FULL))
    else $error("clipped frame with in-range code");

endmodule

bind dac_code_scale_and_serialize dcs_checker u_dcs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .serial_bit   (out_ch.serial_bit),
  .bit_position (out_ch.bit_position),
  .dac_code     (out_ch.dac_code),
  .clipped      (out_ch.clipped),
  .last_bit     (out_ch.last_bit)
);
